/* hdl/wwvb_pkg.sv */
// wwvb_pkg: shared types, constants and helper functions for the wwvb frame encoder
// no dependencies; imported by the interfaces and every rtl module
`default_nettype none

package wwvb_pkg;

  localparam int unsigned FRAME_LEN = 60;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned DOY_W     = 9;

  // frame symbol codes
  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_ONE  = 2'd1,
    SYM_MARK = 2'd2
  } sym_t;

  // data bits of one frame, one flag per second (markers are added by the back end)
  typedef logic [FRAME_LEN-1:0] frame_bits_t;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // cumulative days before the start of each month, normal and leap rows
  function automatic logic [DOY_W-1:0] cum_days(input logic leap, input logic [3:0] month);
    logic [DOY_W-1:0] d;
    begin
      case (month)
        4'd2:    d = 9'd31;
        4'd3:    d = leap ? 9'd60  : 9'd59;
        4'd4:    d = leap ? 9'd91  : 9'd90;
        4'd5:    d = leap ? 9'd121 : 9'd120;
        4'd6:    d = leap ? 9'd152 : 9'd151;
        4'd7:    d = leap ? 9'd182 : 9'd181;
        4'd8:    d = leap ? 9'd213 : 9'd212;
        4'd9:    d = leap ? 9'd244 : 9'd243;
        4'd10:   d = leap ? 9'd274 : 9'd273;
        4'd11:   d = leap ? 9'd305 : 9'd304;
        4'd12:   d = leap ? 9'd335 : 9'd334;
        default: d = 9'd0;
      endcase
      return d;
    end
  endfunction

  // tens digit of a value below 100, by parallel compares
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [3:0] t;
    begin
      t = 4'd0;
      for (int k = 1; k < 10; k++) begin
        if (v >= 7'(10 * k)) t = 4'(k);
      end
      return t;
    end
  endfunction

  // true at the fixed marker seconds
  function automatic logic is_marker(input logic [POS_W-1:0] pos);
    begin
      return (pos == 6'd0)  || (pos == 6'd9)  || (pos == 6'd19) || (pos == 6'd29) ||
             (pos == 6'd39) || (pos == 6'd49) || (pos == 6'd59);
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/wwvb_if.sv */
// wwvb_in_if / wwvb_out_if: valid-ready channels for time items and frame symbols
// depends on wwvb_pkg
`default_nettype none

interface wwvb_in_if;
  import wwvb_pkg::*;
  logic       valid;
  logic       ready;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [4:0] day;
  logic [3:0] month;
  logic [6:0] year;

  modport source (output valid, output minute, output hour, output day, output month,
                  output year, input ready);
  modport sink   (input valid, input minute, input hour, input day, input month,
                  input year, output ready);
endinterface

interface wwvb_out_if;
  import wwvb_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       symbol;
  logic [POS_W-1:0] position;
  logic             last;

  modport source (output valid, output symbol, output position, output last, input ready);
  modport sink   (input valid, input symbol, input position, input last, output ready);
endinterface

`default_nettype wire

/* hdl/wwvb_front.sv */
// wwvb_front: accepts time items, clamps fields, builds day of year and the frame bit word
// depends on wwvb_pkg; feeds wwvb_queue
`default_nettype none

module wwvb_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [5:0]            in_minute,
  input  wire logic [4:0]            in_hour,
  input  wire logic [4:0]            in_day,
  input  wire logic [3:0]            in_month,
  input  wire logic [6:0]            in_year,
  input  wire wwvb_pkg::q_stat_t     q_stat,
  output logic                       q_push,
  output wwvb_pkg::frame_bits_t      q_data
);
  import wwvb_pkg::*;

  logic             s_v_r, s_v_nxt;
  logic [5:0]       s_min_r;
  logic [4:0]       s_hr_r;
  logic [6:0]       s_yr_r;
  logic             s_leap_r;
  logic [DOY_W-1:0] s_doy_r;

  logic [5:0]       c_min;
  logic [4:0]       c_hr, c_day;
  logic [3:0]       c_mon;
  logic [6:0]       c_yr;
  logic             c_leap;
  logic             in_fire;

  // saturate out-of-range fields
  always_comb begin
    c_min  = (in_minute > 6'd59) ? 6'd59 : in_minute;
    c_hr   = (in_hour > 5'd23) ? 5'd23 : in_hour;
    c_day  = (in_day == 5'd0) ? 5'd1 : in_day;
    c_mon  = (in_month == 4'd0) ? 4'd1 : ((in_month > 4'd12) ? 4'd12 : in_month);
    c_yr   = (in_year > 7'd99) ? 7'd99 : in_year;
    c_leap = (c_yr[1:0] == 2'b00);
  end

  assign q_push   = s_v_r && !q_stat.full;
  assign in_ready = !s_v_r || !q_stat.full;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s_v_nxt = s_v_r;
    if (in_fire) begin
      s_v_nxt = 1'b1;
    end else if (q_push) begin
      s_v_nxt = 1'b0;
    end
  end

  // stage register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else begin
      s_v_r <= s_v_nxt;
    end
  end

  // stage register: clamped fields and day of year
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_min_r  <= c_min;
      s_hr_r   <= c_hr;
      s_yr_r   <= c_yr;
      s_leap_r <= c_leap;
      s_doy_r  <= cum_days(c_leap, c_mon) + DOY_W'(c_day);
    end
  end

  // bcd digits
  logic [3:0]       mt, mu, ht, hu, dt, du, yt, yu;
  logic [1:0]       dh;
  logic [DOY_W-1:0] d_rem;

  always_comb begin
    mt = tens_of({1'b0, s_min_r});
    mu = 4'(s_min_r - ({2'b00, mt} * 6'd10));
    ht = tens_of({2'b00, s_hr_r});
    hu = 4'(s_hr_r - ({1'b0, ht} * 5'd10));
    yt = tens_of(s_yr_r);
    yu = 4'(s_yr_r - ({3'b000, yt} * 7'd10));
    if (s_doy_r >= 9'd300) begin
      dh = 2'd3;
      d_rem = s_doy_r - 9'd300;
    end else if (s_doy_r >= 9'd200) begin
      dh = 2'd2;
      d_rem = s_doy_r - 9'd200;
    end else if (s_doy_r >= 9'd100) begin
      dh = 2'd1;
      d_rem = s_doy_r - 9'd100;
    end else begin
      dh = 2'd0;
      d_rem = s_doy_r;
    end
    dt = tens_of(d_rem[6:0]);
    du = 4'(d_rem[6:0] - ({3'b000, dt} * 7'd10));
  end

  // place weighted bcd bits at their seconds
  always_comb begin
    q_data = '0;
    q_data[1]  = mt[2]; q_data[2]  = mt[1]; q_data[3]  = mt[0];
    q_data[5]  = mu[3]; q_data[6]  = mu[2]; q_data[7]  = mu[1]; q_data[8]  = mu[0];
    q_data[12] = ht[1]; q_data[13] = ht[0];
    q_data[15] = hu[3]; q_data[16] = hu[2]; q_data[17] = hu[1]; q_data[18] = hu[0];
    q_data[22] = dh[1]; q_data[23] = dh[0];
    q_data[25] = dt[3]; q_data[26] = dt[2]; q_data[27] = dt[1]; q_data[28] = dt[0];
    q_data[30] = du[3]; q_data[31] = du[2]; q_data[32] = du[1]; q_data[33] = du[0];
    q_data[45] = yt[3]; q_data[46] = yt[2]; q_data[47] = yt[1]; q_data[48] = yt[0];
    q_data[50] = yu[3]; q_data[51] = yu[2]; q_data[52] = yu[1]; q_data[53] = yu[0];
    q_data[55] = s_leap_r;
  end

endmodule

`default_nettype wire

/* hdl/wwvb_queue.sv */
// wwvb_queue: two-entry first-word-fall-through queue of frame bit words
// depends on wwvb_pkg; sits between wwvb_front and wwvb_back
`default_nettype none

module wwvb_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire wwvb_pkg::frame_bits_t wr_data,
  input  wire logic                  pop,
  output wwvb_pkg::frame_bits_t      rd_data,
  output wwvb_pkg::q_stat_t          stat
);
  import wwvb_pkg::*;

  frame_bits_t mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);
  assign rd_data    = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* hdl/wwvb_back.sv */
// wwvb_back: serializes one frame word into 60 symbols through an output register
// depends on wwvb_pkg; reads from wwvb_queue
`default_nettype none

module wwvb_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire wwvb_pkg::q_stat_t     q_stat,
  input  wire wwvb_pkg::frame_bits_t q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_symbol,
  output logic [wwvb_pkg::POS_W-1:0] out_position,
  output logic                       out_last
);
  import wwvb_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  logic             act_r, act_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  frame_bits_t      word_r;
  logic             ov_r, ov_nxt;
  sym_t             sym_r, sym_nxt;
  logic [POS_W-1:0] opos_r, opos_nxt;
  logic             olast_r, olast_nxt;
  logic             adv;

  // output register is free or being drained
  assign adv   = !ov_r || out_ready;
  assign q_pop = adv && !act_r && !q_stat.empty;

  always_comb begin
    act_nxt   = act_r;
    pos_nxt   = pos_r;
    ov_nxt    = ov_r && !out_ready;
    sym_nxt   = sym_r;
    opos_nxt  = opos_r;
    olast_nxt = olast_r;
    if (adv && act_r) begin
      // emit the symbol for the current second
      ov_nxt    = 1'b1;
      opos_nxt  = pos_r;
      olast_nxt = (pos_r == LAST_POS);
      if (is_marker(pos_r)) begin
        sym_nxt = SYM_MARK;
      end else if (word_r[pos_r]) begin
        sym_nxt = SYM_ONE;
      end else begin
        sym_nxt = SYM_ZERO;
      end
      pos_nxt = pos_r + 1'b1;
      if (pos_r == LAST_POS) begin
        act_nxt = 1'b0;
      end
    end else if (q_pop) begin
      // start a new frame: second zero is always a marker
      ov_nxt    = 1'b1;
      opos_nxt  = '0;
      olast_nxt = 1'b0;
      sym_nxt   = SYM_MARK;
      pos_nxt   = POS_W'(1);
      act_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    sym_r   <= sym_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
    if (q_pop) begin
      word_r <= q_data;
    end
  end

  assign out_valid    = ov_r;
  assign out_symbol   = sym_r;
  assign out_position = opos_r;
  assign out_last     = olast_r;

endmodule

`default_nettype wire

/* hdl/wwvb_frame_encoder_unit.sv */
// wwvb_frame_encoder_unit: wwvb minute frame encoder top level
// depends on wwvb_pkg, wwvb_if, wwvb_front, wwvb_queue, wwvb_back
//
// usage:
//   in_ch takes one utc time item per beat (minute, hour, day, month, two-digit
//   year); out fields beyond their range are saturated. out_ch gives the 60 symbols
//   of the matching frame in second order, one beat each, with last on second 59.
//   an accepted item passes the front stage, the queue and the output register
//   before its first symbol is shown. each item gives one frame of 60 beats; the
//   back end serializer emits one symbol per cycle while out_ch does not stall,
//   and frames follow each other back to back once the next item is queued.
//   the front stage and a two-entry queue hold up to three items ahead of the
//   frame being sent, so in_ch keeps accepting while a frame is in flight.
//   when out_ch stalls, the output register holds its beat and the serializer
//   waits; in_ch drops ready once the front stage and the queue are full.
//   reset (rst_n low, synchronous) empties the stage, queue and output register;
//   no partial frame is sent afterwards.
`default_nettype none

module wwvb_frame_encoder_unit (
  input wire logic clk,
  input wire logic rst_n,
  wwvb_in_if.sink  in_ch,
  wwvb_out_if.source out_ch
);
  import wwvb_pkg::*;

  q_stat_t     q_stat;
  logic        q_push, q_pop;
  frame_bits_t q_wdata, q_rdata;

  wwvb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_minute (in_ch.minute),
    .in_hour   (in_ch.hour),
    .in_day    (in_ch.day),
    .in_month  (in_ch.month),
    .in_year   (in_ch.year),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  wwvb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  wwvb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_symbol   (out_ch.symbol),
    .out_position (out_ch.position),
    .out_last     (out_ch.last)
  );

endmodule

`default_nettype wire

/* hdl/wwvb_checker.sv */
// wwvb_checker: port-level assertions for wwvb_frame_encoder_unit, bound to the top level
// depends on wwvb_pkg and wwvb_frame_encoder_unit
`default_nettype none

module wwvb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_symbol,
  input wire logic [5:0] out_position,
  input wire logic       out_last
);
  import wwvb_pkg::*;

  // no beat is shown right after a reset cycle
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) &&
      $stable(out_position) && $stable(out_last))
    else $error("stalled output beat changed");

  // last marks exactly second 59
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_position == 6'd59)))
    else $error("last flag does not match position");

  // marker seconds always carry a marker
  a_markers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_position == 6'd0 || out_position == 6'd9 || out_position == 6'd19 ||
      out_position == 6'd29 || out_position == 6'd39 || out_position == 6'd49 ||
      out_position == 6'd59) |-> out_symbol == SYM_MARK)
    else $error("missing marker");

  // data seconds never carry a marker or an unused code
  a_data_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !(out_position == 6'd0 || out_position == 6'd9 || out_position == 6'd19 ||
      out_position == 6'd29 || out_position == 6'd39 || out_position == 6'd49 ||
      out_position == 6'd59) |-> (out_symbol == SYM_ZERO || out_symbol == SYM_ONE))
    else $error("bad data symbol");

endmodule

bind wwvb_frame_encoder_unit wwvb_checker u_wwvb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_symbol   (out_ch.symbol),
  .out_position (out_ch.position),
  .out_last     (out_ch.last)
);

`default_nettype wire

/* bench/wwvb_frame_encoder_unit_tb.sv */
// wwvb_frame_encoder_unit_tb: self-checking bench for the wwvb minute frame encoder
// drives utc time beats, predicts all 60 frame symbols of each and checks them in order
// depends on wwvb_pkg, wwvb_if and wwvb_frame_encoder_unit
`timescale 1ns / 1ps

module wwvb_frame_encoder_unit_tb;
  import wwvb_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  // days before the first of each month in a common year, indexed by month
  localparam int unsigned DAYS_BEFORE [13] =
    '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } utc_time_t;

  typedef struct packed {
    sym_t             symbol;
    logic [POS_W-1:0] position;
    logic             last;
  } frame_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wwvb_in_if  in_ch();
  wwvb_out_if out_ch();

  wwvb_frame_encoder_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  utc_time_t   time_backlog[$];
  frame_beat_t beats_due[$];

  logic        in_acc = 1'b0;
  logic        out_acc = 1'b0;
  int unsigned in_gap_max = 8;
  int unsigned out_stall_max = 8;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_draw = 0;
  int unsigned hold_left = 0;
  int unsigned hold_ask = 0;
  int unsigned hold_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned times_taken = 0;
  int unsigned beats_checked = 0;
  int unsigned n_directed = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned fail_cnt = 0;
  frame_beat_t want;
  frame_beat_t got;

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // write a digit msb first into consecutive frame seconds
  function automatic void put_bcd(inout logic [FRAME_LEN-1:0] ones, input int unsigned pos,
                                  input int unsigned nbits, input int unsigned digit);
    for (int unsigned k = 0; k < nbits; k++) begin
      ones[pos + k] = 1'((digit >> (nbits - 1 - k)) & 1);
    end
  endfunction

  // build the expected 60 symbol beats of one time item
  function automatic void predict_frame(input utc_time_t t);
    int unsigned      mi, hr, dy, mo, yr, doy;
    logic             leap;
    logic [FRAME_LEN-1:0] ones;
    frame_beat_t      b;
    mi = (t.minute > 59) ? 59 : t.minute;
    hr = (t.hour > 23) ? 23 : t.hour;
    dy = (t.day == 0) ? 1 : t.day;
    mo = (t.month == 0) ? 1 : ((t.month > 12) ? 12 : t.month);
    yr = (t.year > 99) ? 99 : t.year;
    leap = (yr % 4 == 0);
    // leap day shifts every month from march on
    doy = DAYS_BEFORE[mo] + dy + ((leap && mo > 2) ? 1 : 0);
    ones = '0;
    put_bcd(ones, 1, 3, mi / 10);
    put_bcd(ones, 5, 4, mi % 10);
    put_bcd(ones, 12, 2, hr / 10);
    put_bcd(ones, 15, 4, hr % 10);
    put_bcd(ones, 22, 2, doy / 100);
    put_bcd(ones, 25, 4, (doy / 10) % 10);
    put_bcd(ones, 30, 4, doy % 10);
    put_bcd(ones, 45, 4, yr / 10);
    put_bcd(ones, 50, 4, yr % 10);
    ones[55] = leap;
    for (int unsigned p = 0; p < FRAME_LEN; p++) begin
      if (p == 0 || p % 10 == 9) begin
        b.symbol = SYM_MARK;
      end else if (ones[p]) begin
        b.symbol = SYM_ONE;
      end else begin
        b.symbol = SYM_ZERO;
      end
      b.position = p[POS_W-1:0];
      b.last = (p == FRAME_LEN - 1);
      beats_due.push_back(b);
    end
  endfunction

  function automatic utc_time_t random_time();
    utc_time_t t;
    // mostly in range, now and then any raw field value
    t.minute = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) :
                  $urandom_range(0, 59));
    t.hour   = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) :
                  $urandom_range(0, 23));
    t.day    = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) :
                  $urandom_range(1, 31));
    t.month  = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) :
                  $urandom_range(1, 12));
    t.year   = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) :
                  $urandom_range(0, 99));
    return t;
  endfunction

  task automatic push_time(input int unsigned mi, input int unsigned hr, input int unsigned dy,
                           input int unsigned mo, input int unsigned yr);
    utc_time_t t;
    t.minute = 6'(mi);
    t.hour   = 5'(hr);
    t.day    = 5'(dy);
    t.month  = 4'(mo);
    t.year   = 7'(yr);
    time_backlog.push_back(t);
  endtask

  // hold off until every queued time has been taken and every symbol has come back
  task automatic wait_for_drain();
    while (time_backlog.size() != 0 || in_ch.valid || beats_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // time beat driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
    end else if (in_ch.valid && !in_acc) begin
      // beat still offered, keep it steady
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      in_ch.valid <= 1'b0;
    end else if (time_backlog.size() != 0) begin
      {in_ch.minute, in_ch.hour, in_ch.day, in_ch.month, in_ch.year} <= time_backlog.pop_front();
      in_ch.valid <= 1'b1;
      gap_left <= $urandom_range(0, in_gap_max);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // symbol receiver: per-beat stalls and the long hold
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (out_acc) begin
      stall_draw = $urandom_range(0, out_stall_max);
      if (stall_draw != 0) begin
        stall_left <= stall_draw - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: check symbol beats, predict accepted times, watchdog
  always @(posedge clk) begin
    in_acc <= in_ch.valid && in_ch.ready;
    out_acc <= out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.symbol = sym_t'(out_ch.symbol);
      got.position = out_ch.position;
      got.last = out_ch.last;
      if (beats_due.size() == 0) begin
        fail_cnt++;
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected symbol beat: symbol %0d position %0d last %0d",
                   got.symbol, got.position, got.last);
        end
      end else begin
        want = beats_due.pop_front();
        if (got.symbol !== want.symbol || got.position !== want.position ||
            got.last !== want.last) begin
          fail_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("symbol beat %0d: expected symbol %0d position %0d last %0d, got %0d %0d %0d",
                     beats_checked, want.symbol, want.position, want.last,
                     got.symbol, got.position, got.last);
          end
        end
        beats_checked++;
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_frame({in_ch.minute, in_ch.hour, in_ch.day, in_ch.month, in_ch.year});
      times_taken++;
    end
    // watchdog on cycles with no beat on either side
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d symbols outstanding",
               idle_cycles, beats_due.size());
      $display("wwvb_frame_encoder_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.minute = '0;
    in_ch.hour   = '0;
    in_ch.day    = '0;
    in_ch.month  = '0;
    in_ch.year   = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, saturation, leap rule, day of year corners
    push_time(0, 0, 1, 1, 0);        // year 00 is leap, jan 1
    push_time(59, 23, 31, 12, 99);   // top of range, common year dec 31
    push_time(63, 31, 31, 15, 127);  // all field bits set, saturate
    push_time(60, 24, 0, 0, 100);    // just past range, day and month zero
    push_time(0, 0, 0, 13, 1);
    push_time(30, 12, 29, 2, 24);    // leap day
    push_time(0, 0, 1, 3, 24);       // march 1 in leap year
    push_time(0, 0, 1, 3, 23);       // march 1 in common year
    push_time(0, 0, 31, 12, 96);     // day 366
    push_time(0, 0, 31, 12, 0);
    push_time(45, 9, 31, 2, 1);      // day past end of month
    push_time(39, 19, 9, 9, 9);
    push_time(10, 10, 10, 10, 10);
    push_time(42, 21, 21, 5, 85);    // alternating bit patterns
    push_time(21, 10, 10, 10, 42);
    push_time(7, 7, 7, 7, 7);
    push_time(0, 0, 28, 2, 4);
    push_time(9, 19, 30, 11, 50);
    push_time(59, 0, 30, 6, 98);
    n_directed = time_backlog.size();
    wait_for_drain();

    // back to back, no idling on either side
    in_gap_max = 0;
    out_stall_max = 0;
    repeat (120) time_backlog.push_back(random_time());
    wait_for_drain();

    // long receiver hold while the sender keeps offering
    out_stall_max = 3;
    hold_ask++;
    repeat (30) time_backlog.push_back(random_time());
    wait_for_drain();

    // random gaps and stalls on both sides, then gaps on the sender side only
    in_gap_max = 8;
    out_stall_max = 8;
    repeat (100) time_backlog.push_back(random_time());
    wait_for_drain();
    out_stall_max = 0;
    repeat (100) time_backlog.push_back(random_time());

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (beats_due.size() != 0) begin
      fail_cnt++;
      $display("%0d expected symbol beats never arrived", beats_due.size());
    end
    $display("covered %0d time items (%0d directed) and %0d checked symbol beats, with",
             times_taken, n_directed, beats_checked);
    $display("  0-8 cycle gaps and stalls, a no-idle stretch and a %0d cycle receiver hold",
             HOLD_CYCLES);
    if (fail_cnt == 0) begin
      $display("wwvb_frame_encoder_unit regression: pass");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("wwvb_frame_encoder_unit regression: fail");
    end
    $finish;
  end

endmodule
